/* rtl/liats_pkg.sv */
// Package for the leading ID3v2 / APEv2 tag stripper.
// Holds the tag constants, magic byte tables, state and verdict types.
// No dependencies; used by leading_id3_ape_tag_stripper.
`timescale 1ns / 1ps

package liats_pkg;

	// Default width of the running skipped-byte counter.
	localparam int SKIP_TOTAL_BITS_DEF = 48;
	// Width of the skipped total shown on the output word.
	localparam int SHOW_BITS = 48;

	// Header window: at most 20 bytes are held, in a 32-slot ring.
	localparam int WIN_DEPTH = 20;
	localparam int WIN_SLOTS = 32;
	localparam int WIN_AW = $clog2(WIN_SLOTS);

	// ID3v2 header layout.
	localparam int ID3_MAGIC_LEN = 3;
	localparam int ID3_HDR_LEN = 10;
	localparam logic [7:0] ID3_FOOTER_FLAG = 8'h10;
	localparam logic [32:0] ID3_BASE_SIZE = 33'd10;
	localparam logic [32:0] ID3_FOOTER_SIZE = 33'd10;

	// APEv2 header layout.
	localparam int APE_MAGIC_LEN = 8;
	localparam int APE_VER_LAST = 11;
	localparam int APE_HDR_LEN = WIN_DEPTH;
	localparam logic [31:0] APE_VER_1000 = 32'd1000;
	localparam logic [31:0] APE_VER_2000 = 32'd2000;
	localparam logic [31:0] APE_HAS_HEADER = 32'h1 << 29;
	localparam logic [31:0] APE_IS_HEADER = 32'h1 << 30;
	localparam logic [32:0] APE_HDR_SIZE = 33'd32;

	// Byte k of "ID3".
	function automatic logic [7:0] id3_magic(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = 8'h49;
			2'd1: c = 8'h44;
			2'd2: c = 8'h33;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Byte k of "APETAGEX".
	function automatic logic [7:0] ape_magic(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0: c = 8'h41;
			3'd1: c = 8'h50;
			3'd2: c = 8'h45;
			3'd3: c = 8'h54;
			3'd4: c = 8'h41;
			3'd5: c = 8'h47;
			3'd6: c = 8'h45;
			3'd7: c = 8'h58;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Outcome of examining one more header byte.
	typedef enum logic [1:0] {
		V_NEED,
		V_OUT,
		V_FOUND
	} verdict_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_EXAM,
		ST_SKIP,
		ST_PASS,
		ST_TAG,
		ST_APPLY,
		ST_RS_RD,
		ST_RS_EV,
		ST_FL_RD,
		ST_FL_WR,
		ST_MARK
	} st_t;

	// One result word as held in the output queue.
	typedef struct packed {
		logic [SHOW_BITS-1:0] skipped_total;
		logic end_of_stream;
		logic has_byte;
		logic [7:0] out_byte;
	} out_word_t;

endpackage

/* rtl/leading_id3_ape_tag_stripper.sv */
// Top level of the leading ID3v2 / APEv2 tag stripper.
// Depends on liats_pkg for constants, magic tables and types.
//
//  channel | dir | tdata (low bit up)               | tuser    | tlast
//  s_*     | in  | in_byte[7:0]                     | -        | in_last
//  m_*     | out | out_byte[7:0], skipped_total[55:8] | has_byte | end_of_stream
//
// Bytes passed, skipped or added to the header window take one state each. A found
// tag then goes through a size check and a counter update. Re-examining held bytes
// and flushing them take a read state, then an evaluate or write state, per byte,
// set by the single window memory with its registered read port. Reset (arst_n)
// clears the sequencer and counters; the window memory needs no clearing pass. A
// stalled m side stops input only once the two-word output queue is full.
`timescale 1ns / 1ps

module leading_id3_ape_tag_stripper #(
	parameter int SKIP_TOTAL_BITS = liats_pkg::SKIP_TOTAL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_byte[7:0], skipped_total[55:8]
	output logic        m_tuser,   // has_byte
	output logic        m_tlast
);

	localparam int AW = liats_pkg::WIN_AW;

	liats_pkg::st_t state_q, state_d;
	liats_pkg::verdict_t verdict;

	logic [AW-1:0] base_q, held_q, scan_q, fl_idx_q;
	logic          last_q, id3_ok_q, ape_ok_q, le_q;
	logic [32:0]   size_q, amt_q, skip_rem_q;
	logic [SKIP_TOTAL_BITS-1:0] skip_cnt_q;
	logic [7:0]    lo_q [5:10];
	logic [7:0]    sz_q [0:3];

	// Window memory and its registered read port.
	logic [7:0]    win_mem [liats_pkg::WIN_SLOTS];
	logic [7:0]    rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] wr_addr, rd_addr;

	// Output queue.
	liats_pkg::out_word_t oq_mem [2];
	logic [1:0]    oq_cnt_q;
	logic          oq_wp_q, oq_rp_q;
	logic          can_push, push, pop;
	liats_pkg::out_word_t push_word;

	logic          accept, cls_act, fl_last, rs_end;
	logic [7:0]    cls_byte;
	logic          id3_m, ape_m;
	logic [31:0]   ape_ver, ape_flags;
	logic [32:0]   id3_size, ape_size, cls_size;
	logic          inc_en;
	logic [32:0]   inc_amt;
	logic [SKIP_TOTAL_BITS:0]   cnt_sum;
	logic [SKIP_TOTAL_BITS-1:0] cnt_next;
	logic [63:0]   cnt_wide;
	logic [liats_pkg::SHOW_BITS-1:0] shown;

	assign accept   = s_tvalid && s_tready;
	assign can_push = (oq_cnt_q != 2'd2);
	assign pop      = m_tvalid && m_tready;
	assign fl_last  = (fl_idx_q == held_q - AW'(1));
	assign rs_end   = (scan_q + AW'(1) == held_q);
	assign cls_act  = (state_q == liats_pkg::ST_RS_EV) ||
		(state_q == liats_pkg::ST_EXAM && accept);

	// Examine one header byte at window position scan_q.
	always_comb begin
		cls_byte = (state_q == liats_pkg::ST_RS_EV) ? rd_q : s_tdata;
		id3_m = id3_ok_q;
		if (scan_q < AW'(liats_pkg::ID3_MAGIC_LEN)) begin
			id3_m = id3_ok_q && (cls_byte == liats_pkg::id3_magic(scan_q[1:0]));
		end
		ape_m = ape_ok_q;
		if (scan_q < AW'(liats_pkg::APE_MAGIC_LEN)) begin
			ape_m = ape_ok_q && (cls_byte == liats_pkg::ape_magic(scan_q[2:0]));
		end
		ape_ver   = {cls_byte, lo_q[10], lo_q[9], lo_q[8]};
		ape_flags = {cls_byte, 24'h0};
		id3_size  = liats_pkg::ID3_BASE_SIZE + (33'(lo_q[6]) << 21) +
			(33'(lo_q[7]) << 14) + (33'(lo_q[8]) << 7) + 33'(cls_byte) +
			(((lo_q[5] & liats_pkg::ID3_FOOTER_FLAG) != 8'h0) ?
			liats_pkg::ID3_FOOTER_SIZE : 33'd0);
		ape_size  = 33'({sz_q[3], sz_q[2], sz_q[1], sz_q[0]}) +
			(((ape_flags & liats_pkg::APE_IS_HEADER) != 32'h0) ?
			liats_pkg::APE_HDR_SIZE : 33'd0);
		verdict  = liats_pkg::V_OUT;
		cls_size = id3_size;
		if (id3_m) begin
			if (scan_q == AW'(liats_pkg::ID3_HDR_LEN - 1)) begin
				verdict = liats_pkg::V_FOUND;
			end else begin
				verdict = liats_pkg::V_NEED;
			end
		end else if (ape_m) begin
			cls_size = ape_size;
			if (scan_q == AW'(liats_pkg::APE_VER_LAST) &&
				!(ape_ver == liats_pkg::APE_VER_1000 ||
				ape_ver == liats_pkg::APE_VER_2000)) begin
				verdict = liats_pkg::V_OUT;
			end else if (scan_q != AW'(liats_pkg::APE_HDR_LEN - 1)) begin
				verdict = liats_pkg::V_NEED;
			end else if ((ape_flags & liats_pkg::APE_HAS_HEADER) == 32'h0 ||
				ape_size == 33'd0) begin
				verdict = liats_pkg::V_OUT;
			end else begin
				verdict = liats_pkg::V_FOUND;
			end
		end
	end

	// Saturating skipped counter and the 48-bit view of it.
	always_comb begin
		cnt_sum  = {1'b0, skip_cnt_q} + (SKIP_TOTAL_BITS + 1)'(inc_amt);
		cnt_next = cnt_sum[SKIP_TOTAL_BITS] ? '1 : cnt_sum[SKIP_TOTAL_BITS-1:0];
		cnt_wide = 64'(skip_cnt_q);
		shown    = (|cnt_wide[63:liats_pkg::SHOW_BITS]) ? '1 :
			cnt_wide[liats_pkg::SHOW_BITS-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			liats_pkg::ST_EXAM: begin
				if (accept) begin
					case (verdict)
						liats_pkg::V_NEED: state_d = s_tlast ? liats_pkg::ST_FL_RD
							: liats_pkg::ST_EXAM;
						liats_pkg::V_FOUND: state_d = liats_pkg::ST_TAG;
						default: state_d = liats_pkg::ST_FL_RD;
					endcase
				end
			end
			liats_pkg::ST_SKIP: begin
				if (accept) begin
					if (s_tlast) begin
						state_d = liats_pkg::ST_MARK;
					end else if (skip_rem_q == 33'd1) begin
						state_d = liats_pkg::ST_EXAM;
					end
				end
			end
			liats_pkg::ST_PASS: begin
				if (accept && s_tlast) begin
					state_d = liats_pkg::ST_EXAM;
				end
			end
			liats_pkg::ST_TAG: state_d = liats_pkg::ST_APPLY;
			liats_pkg::ST_APPLY: begin
				if (le_q && held_q != size_q[AW-1:0]) begin
					state_d = liats_pkg::ST_RS_RD;
				end else if (last_q) begin
					state_d = liats_pkg::ST_MARK;
				end else begin
					state_d = le_q ? liats_pkg::ST_EXAM : liats_pkg::ST_SKIP;
				end
			end
			liats_pkg::ST_RS_RD: state_d = liats_pkg::ST_RS_EV;
			liats_pkg::ST_RS_EV: begin
				case (verdict)
					liats_pkg::V_NEED: begin
						if (!rs_end) begin
							state_d = liats_pkg::ST_RS_RD;
						end else begin
							state_d = last_q ? liats_pkg::ST_FL_RD : liats_pkg::ST_EXAM;
						end
					end
					liats_pkg::V_FOUND: state_d = liats_pkg::ST_TAG;
					default: state_d = liats_pkg::ST_FL_RD;
				endcase
			end
			liats_pkg::ST_FL_RD: state_d = liats_pkg::ST_FL_WR;
			liats_pkg::ST_FL_WR: begin
				if (can_push) begin
					if (!fl_last) begin
						state_d = liats_pkg::ST_FL_RD;
					end else begin
						state_d = last_q ? liats_pkg::ST_EXAM : liats_pkg::ST_PASS;
					end
				end
			end
			liats_pkg::ST_MARK: begin
				if (can_push) begin
					state_d = liats_pkg::ST_EXAM;
				end
			end
			default: state_d = liats_pkg::ST_EXAM;
		endcase
	end

	// Handshake, memory and queue strobes.
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		push      = 1'b0;
		inc_en    = 1'b0;
		inc_amt   = 33'd1;
		push_word = '{skipped_total: shown, end_of_stream: 1'b0, has_byte: 1'b1,
			out_byte: rd_q};
		case (state_q)
			liats_pkg::ST_EXAM: begin
				s_tready = 1'b1;
				mem_we   = accept;
			end
			liats_pkg::ST_SKIP: begin
				s_tready = 1'b1;
				inc_en   = accept;
			end
			liats_pkg::ST_PASS: begin
				s_tready = can_push;
				push     = accept;
				push_word.out_byte      = s_tdata;
				push_word.end_of_stream = s_tlast;
			end
			liats_pkg::ST_APPLY: begin
				inc_en  = 1'b1;
				inc_amt = amt_q;
			end
			liats_pkg::ST_RS_RD: mem_re = 1'b1;
			liats_pkg::ST_FL_RD: mem_re = 1'b1;
			liats_pkg::ST_FL_WR: begin
				push = can_push;
				push_word.end_of_stream = last_q && fl_last;
			end
			liats_pkg::ST_MARK: begin
				push = can_push;
				push_word.out_byte      = 8'h00;
				push_word.has_byte      = 1'b0;
				push_word.end_of_stream = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign wr_addr = base_q + held_q;
	assign rd_addr = base_q + ((state_q == liats_pkg::ST_FL_RD) ? fl_idx_q : scan_q);

	// Window memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[wr_addr] <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= win_mem[rd_addr];
		end
	end

	// Sequencer and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= liats_pkg::ST_EXAM;
			base_q     <= '0;
			held_q     <= '0;
			scan_q     <= '0;
			fl_idx_q   <= '0;
			last_q     <= 1'b0;
			id3_ok_q   <= 1'b1;
			ape_ok_q   <= 1'b1;
			skip_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (inc_en) begin
				skip_cnt_q <= cnt_next;
			end
			case (state_q)
				liats_pkg::ST_EXAM: begin
					if (accept) begin
						held_q   <= held_q + AW'(1);
						last_q   <= s_tlast;
						fl_idx_q <= '0;
						if (verdict == liats_pkg::V_NEED) begin
							scan_q   <= scan_q + AW'(1);
							id3_ok_q <= id3_m;
							ape_ok_q <= ape_m;
						end
					end
				end
				liats_pkg::ST_APPLY: begin
					if (le_q) begin
						base_q <= base_q + size_q[AW-1:0];
						held_q <= held_q - size_q[AW-1:0];
					end else begin
						held_q <= '0;
					end
					scan_q   <= '0;
					id3_ok_q <= 1'b1;
					ape_ok_q <= 1'b1;
				end
				liats_pkg::ST_RS_EV: begin
					fl_idx_q <= '0;
					if (verdict == liats_pkg::V_NEED) begin
						scan_q   <= scan_q + AW'(1);
						id3_ok_q <= id3_m;
						ape_ok_q <= ape_m;
					end
				end
				liats_pkg::ST_FL_WR: begin
					if (can_push) begin
						fl_idx_q <= fl_idx_q + AW'(1);
						if (fl_last) begin
							held_q   <= '0;
							scan_q   <= '0;
							id3_ok_q <= 1'b1;
							ape_ok_q <= 1'b1;
						end
					end
				end
				default: begin
					last_q <= last_q;
				end
			endcase
		end
	end

	// Header fields, tag size and skip length.
	always_ff @(posedge clk) begin
		if (cls_act) begin
			for (int k = 5; k <= 10; k++) begin
				if (scan_q == AW'(k)) begin
					lo_q[k] <= cls_byte;
				end
			end
			for (int k = 0; k < 4; k++) begin
				if (scan_q == AW'(k + 12)) begin
					sz_q[k] <= cls_byte;
				end
			end
			if (verdict == liats_pkg::V_FOUND) begin
				size_q <= cls_size;
			end
		end
		if (state_q == liats_pkg::ST_TAG) begin
			le_q       <= (size_q <= 33'(held_q));
			amt_q      <= (size_q <= 33'(held_q)) ? size_q : 33'(held_q);
			skip_rem_q <= size_q - 33'(held_q);
		end else if (state_q == liats_pkg::ST_SKIP && accept) begin
			skip_rem_q <= skip_rem_q - 33'd1;
		end
	end

	// Two-word output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_cnt_q <= '0;
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
		end else begin
			if (push) begin
				oq_wp_q <= ~oq_wp_q;
			end
			if (pop) begin
				oq_rp_q <= ~oq_rp_q;
			end
			if (push && !pop) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (pop && !push) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_mem[oq_wp_q] <= push_word;
		end
	end

	// Master side.
	assign m_tvalid = (oq_cnt_q != 2'd0);
	assign m_tdata  = {oq_mem[oq_rp_q].skipped_total, oq_mem[oq_rp_q].out_byte};
	assign m_tuser  = oq_mem[oq_rp_q].has_byte;
	assign m_tlast  = oq_mem[oq_rp_q].end_of_stream;

endmodule
